/* rtl/hop_pkg.sv */
// ----------------------------------------------------------------------------
// hop_pkg
// Shared widths, codes and types of the holdover error predictor.
// ----------------------------------------------------------------------------
package hop_pkg;

  // square root chain: 112-bit radicand, one root bit per cell
  localparam int unsigned SQ_XW  = 112;
  localparam int unsigned SQ_RTW = SQ_XW / 2;
  localparam int unsigned SQ_RMW = SQ_RTW + 2;
  localparam int unsigned SQ_N   = SQ_RTW;

  // divider chain: 40 quotient bits, divisor up to 47 bits
  localparam int unsigned DV_NW  = 40;
  localparam int unsigned DV_DW  = 47;
  localparam int unsigned DV_RMW = DV_DW + 1;
  localparam int unsigned DV_N   = DV_NW;

  localparam logic [47:0] ERR_MAX  = '1;
  localparam logic [39:0] TIME_MAX = '1;

  typedef enum logic [2:0] {
    REG_BASE  = 3'd0,
    REG_DRIFT = 3'd1,
    REG_TEMPC = 3'd2,
    REG_AGE   = 3'd3
  } reg_idx_e;

  // how the final result of an item is formed
  typedef enum logic [2:0] {
    KIND_ERR  = 3'd0,
    KIND_ZERO = 3'd1,
    KIND_INF  = 3'd2,
    KIND_SAT  = 3'd3,
    KIND_DIV  = 3'd4
  } kind_e;

  typedef struct packed {
    logic [39:0] base;
    logic [31:0] drift;
    logic [31:0] tempc;
    logic [30:0] age;   // ageing clamped at zero
  } cfg_t;

  typedef struct packed {
    logic        op;
    logic        bpos;
    logic [47:0] err;
    logic [46:0] r;
    logic [40:0] bud;
  } sq_side_t;

  typedef struct packed {
    kind_e       kind;
    logic [47:0] err;
  } dv_side_t;

endpackage

/* rtl/holdover_error_predictor.sv */
// ----------------------------------------------------------------------------
// holdover_error_predictor
// Holdover error model: predicted error and time to threshold.
// ----------------------------------------------------------------------------
// channel   | dir | handshake        | payload
// s_axis    | in  | tvalid / tready  | tdata: elapsed, temp delta, threshold; tuser: op
// m_axis    | out | tvalid / tready  | tdata: error, time; tuser: time infinite
// cfg       | in  | cfg_we_i         | cfg_idx_i, cfg_data_i
//
// one transaction accepted per cycle while the output is not stalled; input to output register:
// 5 product stages, 56 square root cells, 1 setup stage, 40 divider cells, output.
// reset clears the configuration registers and all valid bits; there is no clearing pass.
// a stalled output freezes the whole chain, and s_axis_tready drops with it.
// ----------------------------------------------------------------------------
module holdover_error_predictor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,   // elapsed_time[31:0], temp_delta[47:32], threshold[87:48]
  input  logic        s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // error_value[47:0], time_value[87:48]
  output logic        m_axis_tuser,   // time_infinite
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [39:0] cfg_data_i
);
  import hop_pkg::*;

  logic [39:0] base_q;
  logic [31:0] drift_q, tempc_q, age_q;
  cfg_t        cfg;
  logic        adv;

  logic                  sq_v    [0:SQ_N];
  logic [SQ_XW-1:0]      sq_x    [0:SQ_N];
  logic [SQ_RMW-1:0]     sq_rem  [0:SQ_N];
  logic [SQ_RTW-1:0]     sq_root [0:SQ_N];
  logic [$bits(sq_side_t)-1:0] sq_sd [0:SQ_N];
  sq_side_t              front_side, sq_end;

  logic                  dv_v    [0:DV_N];
  logic [DV_NW-1:0]      dv_n    [0:DV_N];
  logic [DV_DW-1:0]      dv_d    [0:DV_N];
  logic [DV_RMW-1:0]     dv_rem  [0:DV_N];
  logic [DV_NW-1:0]      dv_q    [0:DV_N];
  logic [$bits(dv_side_t)-1:0] dv_sd [0:DV_N];
  dv_side_t              dv_end;

  // setup stage
  logic [64:0]      num;
  logic [DV_DW-1:0] den;
  logic [55:0]      sdiff;
  kind_e            kind;
  logic             su_v_q;
  dv_side_t         su_side_q;
  logic [DV_NW-1:0] su_n_q;
  logic [DV_DW-1:0] su_d_q;
  logic [DV_RMW-1:0] su_rem_q;

  logic        out_v_q;
  logic [47:0] out_err_q;
  logic [39:0] out_time_q;
  logic        out_inf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      drift_q <= '0;
      tempc_q <= '0;
      age_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_BASE:  base_q  <= cfg_data_i;
        REG_DRIFT: drift_q <= cfg_data_i[31:0];
        REG_TEMPC: tempc_q <= cfg_data_i[31:0];
        REG_AGE:   age_q   <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  assign cfg.base  = base_q;
  assign cfg.drift = drift_q;
  assign cfg.tempc = tempc_q;
  assign cfg.age   = age_q[31] ? '0 : age_q[30:0];

  assign adv           = !out_v_q || m_axis_tready;
  assign s_axis_tready = adv;

  hop_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s_axis_tvalid),
    .op_i    (s_axis_tuser),
    .t8_i    (s_axis_tdata[31:0]),
    .dt_i    (s_axis_tdata[47:32]),
    .thr_i   (s_axis_tdata[87:48]),
    .cfg_i   (cfg),
    .valid_o (sq_v[0]),
    .x_o     (sq_x[0]),
    .side_o  (front_side)
  );

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_sd[0]   = front_side;

  for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
    hop_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (sq_v[i]),
      .x_i     (sq_x[i]),
      .rem_i   (sq_rem[i]),
      .root_i  (sq_root[i]),
      .side_i  (sq_sd[i]),
      .valid_o (sq_v[i+1]),
      .x_o     (sq_x[i+1]),
      .rem_o   (sq_rem[i+1]),
      .root_o  (sq_root[i+1]),
      .side_o  (sq_sd[i+1])
    );
  end

  assign sq_end = sq_sd[SQ_N];
  assign sdiff  = sq_root[SQ_N] - {1'b0, sq_end.r, 8'd0};

  always_comb begin
    num  = {sq_end.bud, 24'd0};
    den  = sq_end.r;
    kind = KIND_DIV;
    if (!sq_end.op) begin
      kind = KIND_ERR;
    end else if (!sq_end.bpos) begin
      kind = KIND_ZERO;
    end else if (cfg.age != '0) begin
      num = {9'd0, sdiff};
      den = {{(DV_DW-31){1'b0}}, cfg.age};
    end else if (sq_end.r == '0) begin
      kind = KIND_INF;
    end
    // quotient beyond 40 bits when the top of the numerator reaches the divisor
    if (kind == KIND_DIV && {22'd0, num[64:40]} >= den) begin
      kind = KIND_SAT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      su_v_q <= 1'b0;
    end else if (adv) begin
      su_v_q <= sq_v[SQ_N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      su_side_q.kind <= kind;
      su_side_q.err  <= sq_end.err;
      su_n_q         <= num[39:0];
      su_d_q         <= den;
      su_rem_q       <= {23'd0, num[64:40]};
    end
  end

  assign dv_v[0]   = su_v_q;
  assign dv_n[0]   = su_n_q;
  assign dv_d[0]   = su_d_q;
  assign dv_rem[0] = su_rem_q;
  assign dv_q[0]   = '0;
  assign dv_sd[0]  = su_side_q;

  for (genvar j = 0; j < DV_N; j++) begin : g_div
    hop_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (dv_v[j]),
      .n_i     (dv_n[j]),
      .d_i     (dv_d[j]),
      .rem_i   (dv_rem[j]),
      .q_i     (dv_q[j]),
      .side_i  (dv_sd[j]),
      .valid_o (dv_v[j+1]),
      .n_o     (dv_n[j+1]),
      .d_o     (dv_d[j+1]),
      .rem_o   (dv_rem[j+1]),
      .q_o     (dv_q[j+1]),
      .side_o  (dv_sd[j+1])
    );
  end

  assign dv_end = dv_sd[DV_N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= dv_v[DV_N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_err_q  <= (dv_end.kind == KIND_ERR) ? dv_end.err : '0;
      out_inf_q  <= (dv_end.kind == KIND_INF);
      case (dv_end.kind) inside
        KIND_DIV:           out_time_q <= dv_q[DV_N];
        KIND_SAT, KIND_INF: out_time_q <= TIME_MAX;
        default:            out_time_q <= '0;
      endcase
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_time_q, out_err_q};
  assign m_axis_tuser  = out_inf_q;

endmodule

/* rtl/hop_front.sv */
// ----------------------------------------------------------------------------
// hop_front
// Five-stage product and sum pipeline: rate, error polynomial, discriminant.
// ----------------------------------------------------------------------------
module hop_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic                 op_i,
  input  logic [31:0]          t8_i,
  input  logic [15:0]          dt_i,
  input  logic [39:0]          thr_i,
  input  hop_pkg::cfg_t        cfg_i,
  output logic                 valid_o,
  output logic [hop_pkg::SQ_XW-1:0] x_o,
  output hop_pkg::sq_side_t    side_o
);
  import hop_pkg::*;

  logic [4:0] v_q;

  // stage 1
  logic [15:0]        adt;
  logic signed [48:0] tcm_d;
  logic               op1_q;
  logic [31:0]        t8_1_q;
  logic signed [48:0] tcm_q;
  logic [63:0]        t2_q;
  logic [41:0]        bud_q;

  // stage 2
  logic signed [49:0] rate_d;
  logic               op2_q;
  logic [31:0]        t8_2_q;
  logic signed [49:0] rate_q;
  logic [62:0]        agel_q, ageh_q, abl_q;
  logic [39:0]        abh_q;
  logic               bpos2_q;
  logic [40:0]        bud2_q;

  // stage 3
  logic [49:0]        rabs;
  logic [46:0]        rm, rp;
  logic               op3_q, rneg3_q, bpos3_q;
  logic [63:0]        rtl_q;
  logic [46:0]        rth_q;
  logic [94:0]        ageterm_q;
  logic [47:0]        rl2_q;
  logic [46:0]        rlh_q;
  logic [45:0]        rh2_q;
  logic [71:0]        ab3_q;
  logic [46:0]        r3_q;
  logic [40:0]        bud3_q;

  // stage 4
  logic [78:0]        rterm;
  logic [97:0]        rmag;
  logic               op4_q, bpos4_q;
  logic [97:0]        bpa_q, rts_q;
  logic [94:0]        r2_q;
  logic [71:0]        ab4_q;
  logic [46:0]        r4_q;
  logic [40:0]        bud4_q;

  // stage 5
  logic               op5_q, bpos5_q;
  logic [97:0]        acc_q;
  logic [95:0]        d_q;
  logic [46:0]        r5_q;
  logic [40:0]        bud5_q;

  assign adt   = dt_i[15] ? (~dt_i + 16'd1) : dt_i;
  assign tcm_d = $signed(cfg_i.tempc) * $signed({1'b0, adt});
  assign rate_d = $signed({{10{cfg_i.drift[31]}}, cfg_i.drift, 8'h00}) +
                  $signed({tcm_q[48], tcm_q});
  assign rabs  = rate_q[49] ? (~rate_q + 50'd1) : rate_q;
  assign rm    = rabs[46:0];
  assign rp    = rate_q[49] ? '0 : rate_q[46:0];
  assign rterm = {15'd0, rtl_q} + {rth_q, 32'd0};
  assign rmag  = {10'd0, rterm, 9'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op1_q   <= op_i;
      t8_1_q  <= t8_i;
      tcm_q   <= tcm_d;
      t2_q    <= t8_i * t8_i;
      bud_q   <= {2'b00, thr_i} - {{2{cfg_i.base[39]}}, cfg_i.base};

      op2_q   <= op1_q;
      t8_2_q  <= t8_1_q;
      rate_q  <= rate_d;
      agel_q  <= cfg_i.age * t2_q[31:0];
      ageh_q  <= cfg_i.age * t2_q[63:32];
      abl_q   <= cfg_i.age * bud_q[31:0];
      abh_q   <= cfg_i.age * bud_q[40:32];
      bpos2_q <= !bud_q[41] && (bud_q != '0);
      bud2_q  <= bud_q[40:0];

      op3_q     <= op2_q;
      rneg3_q   <= rate_q[49];
      rtl_q     <= rm[31:0] * t8_2_q;
      rth_q     <= rm[46:32] * t8_2_q;
      ageterm_q <= {32'd0, agel_q} + {ageh_q, 32'd0};
      rl2_q     <= rp[23:0] * rp[23:0];
      rlh_q     <= rp[23:0] * rp[46:24];
      rh2_q     <= rp[46:24] * rp[46:24];
      ab3_q     <= {9'd0, abl_q} + {abh_q, 32'd0};
      r3_q      <= rp;
      bpos3_q   <= bpos2_q;
      bud3_q    <= bud2_q;

      op4_q   <= op3_q;
      bpa_q   <= {{25{cfg_i.base[39]}}, cfg_i.base, 33'd0} + {3'd0, ageterm_q};
      rts_q   <= rneg3_q ? (~rmag + 98'd1) : rmag;
      // cross term rl*rh appears twice, hence one bit more of shift
      r2_q    <= {1'b0, rh2_q, 48'd0} + {23'd0, rlh_q, 25'd0} + {47'd0, rl2_q};
      ab4_q   <= ab3_q;
      r4_q    <= r3_q;
      bpos4_q <= bpos3_q;
      bud4_q  <= bud3_q;

      op5_q   <= op4_q;
      acc_q   <= bpa_q + rts_q;
      d_q     <= {1'b0, r2_q} + {7'd0, ab4_q, 17'd0};
      r5_q    <= r4_q;
      bpos5_q <= bpos4_q;
      bud5_q  <= bud4_q;
    end
  end

  assign valid_o     = v_q[4];
  assign x_o         = {d_q, 16'd0};
  assign side_o.op   = op5_q;
  assign side_o.bpos = bpos5_q;
  assign side_o.err  = acc_q[97] ? '0 : ((|acc_q[97:81]) ? ERR_MAX : acc_q[80:33]);
  assign side_o.r    = r5_q;
  assign side_o.bud  = bud5_q;

endmodule

/* rtl/hop_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// hop_sqrt_cell
// One digit step of the integer square root; one root bit per cell.
// ----------------------------------------------------------------------------
module hop_sqrt_cell #(
  parameter int unsigned XW  = hop_pkg::SQ_XW,
  parameter int unsigned RTW = hop_pkg::SQ_RTW,
  parameter int unsigned RMW = hop_pkg::SQ_RMW,
  parameter int unsigned SW  = $bits(hop_pkg::sq_side_t)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [XW-1:0]  x_i,
  input  logic [RMW-1:0] rem_i,
  input  logic [RTW-1:0] root_i,
  input  logic [SW-1:0]  side_i,
  output logic           valid_o,
  output logic [XW-1:0]  x_o,
  output logic [RMW-1:0] rem_o,
  output logic [RTW-1:0] root_o,
  output logic [SW-1:0]  side_o
);
  logic [RMW-1:0] rem_sh, trial;
  logic           ge;

  assign rem_sh = {rem_i[RMW-3:0], x_i[XW-1:XW-2]};
  assign trial  = {root_i[RMW-3:0], 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o    <= {x_i[XW-3:0], 2'b00};
      rem_o  <= ge ? (rem_sh - trial) : rem_sh;
      root_o <= {root_i[RTW-2:0], ge};
      side_o <= side_i;
    end
  end

endmodule

/* rtl/hop_div_cell.sv */
// ----------------------------------------------------------------------------
// hop_div_cell
// One restoring division step; one quotient bit per cell.
// ----------------------------------------------------------------------------
module hop_div_cell #(
  parameter int unsigned NW  = hop_pkg::DV_NW,
  parameter int unsigned DW  = hop_pkg::DV_DW,
  parameter int unsigned RMW = hop_pkg::DV_RMW,
  parameter int unsigned SW  = $bits(hop_pkg::dv_side_t)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [NW-1:0]  n_i,
  input  logic [DW-1:0]  d_i,
  input  logic [RMW-1:0] rem_i,
  input  logic [NW-1:0]  q_i,
  input  logic [SW-1:0]  side_i,
  output logic           valid_o,
  output logic [NW-1:0]  n_o,
  output logic [DW-1:0]  d_o,
  output logic [RMW-1:0] rem_o,
  output logic [NW-1:0]  q_o,
  output logic [SW-1:0]  side_o
);
  logic [RMW-1:0] rs, dx;
  logic           ge;

  assign rs = {rem_i[RMW-2:0], n_i[NW-1]};
  assign dx = {{(RMW-DW){1'b0}}, d_i};
  assign ge = rs >= dx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_o    <= {n_i[NW-2:0], 1'b0};
      d_o    <= d_i;
      rem_o  <= ge ? (rs - dx) : rs;
      q_o    <= {q_i[NW-2:0], ge};
      side_o <= side_i;
    end
  end

endmodule

/* rtl/hop_checker.sv */
// ----------------------------------------------------------------------------
// hop_checker
// Port-level checks of the holdover error predictor, bound to the top level.
// ----------------------------------------------------------------------------
module hop_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // a stalled result stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");

  // the whole chain freezes while the output is stalled
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output stalled");

  // a transaction carries either an error or a time, never both
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[47:0] != 48'd0 |->
      m_axis_tdata[87:48] == 40'd0 && !m_axis_tuser)
    else $error("error and time both set");

  // never reached means the time reads as saturated
  a_inf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[87:48] == 40'hFF_FFFF_FFFF)
    else $error("infinite time not saturated");

endmodule

bind holdover_error_predictor hop_checker u_hop_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* bench/holdover_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// holdover_checker
// Watches the input, output and register write channels of the holdover error
// predictor, works out each result from its own copy of the registers and
// compares every output transaction, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module holdover_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,   // elapsed_time[31:0], temp_delta[47:32], threshold[87:48]
  input  logic        s_axis_tuser,   // op
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [87:0] m_axis_tdata,   // error_value[47:0], time_value[87:48]
  input  logic        m_axis_tuser,   // time_infinite
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [39:0] cfg_data_i,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned results_seen
);
  import hop_pkg::*;

  typedef struct packed {
    logic [47:0] err;
    logic [39:0] tsec;
    logic        inf;
  } hold_result_t;

  localparam logic signed [127:0] ERR_CAP  = 128'hFFFF_FFFF_FFFF;
  localparam logic signed [127:0] TIME_CAP = 128'hFF_FFFF_FFFF;

  logic signed [39:0] base_q;
  logic signed [31:0] drift_q;
  logic signed [31:0] tempc_q;
  logic signed [31:0] age_q;

  hold_result_t due_q[$];
  int unsigned  nfail;

  function automatic logic [63:0] root_floor(logic [127:0] x);
    logic [63:0]  r;
    logic [63:0]  c;
    logic [127:0] sq;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c  = r | (64'd1 << b);
      sq = {64'd0, c} * {64'd0, c};
      if (sq <= x) r = c;
    end
    return r;
  endfunction

  function automatic hold_result_t holdover_eval(logic time_query, logic [31:0] t8,
                                                 logic signed [15:0] dtemp,
                                                 logic [39:0] thr);
    hold_result_t       res;
    logic signed [127:0] b, dr, tc, ag, adt, rate, t, acc, q, bud, r, d, tq;
    logic [63:0]        s;
    res  = '0;
    b    = base_q;
    dr   = drift_q;
    tc   = tempc_q;
    ag   = (age_q > 0) ? 128'(age_q) : 128'sd0;
    adt  = dtemp;
    if (adt < 0) adt = -adt;
    rate = dr * 256 + tc * adt;
    if (!time_query) begin
      t   = {96'd0, t8};
      acc = (b <<< 33) + rate * t * 512 + ag * t * t;
      if (acc >= 0) begin
        q       = acc >>> 33;
        res.err = (q > ERR_CAP) ? ERR_MAX : q[47:0];
      end
    end else begin
      bud = $signed({88'd0, thr}) - b;
      r   = (rate < 0) ? 128'sd0 : rate;
      if (bud <= 0) begin
        res.tsec = '0;
      end else if (ag > 0) begin
        d  = (r * r + ag * (bud <<< 17)) <<< 16;
        s  = root_floor(d);
        tq = ($signed({64'd0, s}) - r * 256) / ag;
        res.tsec = (tq > TIME_CAP) ? TIME_MAX : tq[39:0];
      end else if (r > 0) begin
        tq = (bud <<< 24) / r;
        res.tsec = (tq > TIME_CAP) ? TIME_MAX : tq[39:0];
      end else begin
        res.tsec = TIME_MAX;
        res.inf  = 1'b1;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    hold_result_t want;
    hold_result_t got;
    if (!rst_ni) begin
      base_q  <= '0;
      drift_q <= '0;
      tempc_q <= '0;
      age_q   <= '0;
      due_q.delete();
      nfail        = 0;
      results_seen <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.err  = m_axis_tdata[47:0];
        got.tsec = m_axis_tdata[87:48];
        got.inf  = m_axis_tuser;
        results_seen <= results_seen + 1;
        if (due_q.size() == 0) begin
          nfail++;
          if (nfail <= 10)
            $display("unexpected result err=%h time=%h inf=%b", got.err, got.tsec, got.inf);
        end else begin
          want = due_q.pop_front();
          if (got.err !== want.err || got.tsec !== want.tsec || got.inf !== want.inf) begin
            nfail++;
            if (nfail <= 10)
              $display("mismatch: err %h/%h time %h/%h inf %b/%b (expected/actual)",
                       want.err, got.err, want.tsec, got.tsec, want.inf, got.inf);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        due_q.push_back(holdover_eval(s_axis_tuser, s_axis_tdata[31:0],
                                      s_axis_tdata[47:32], s_axis_tdata[87:48]));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_BASE:  base_q  <= cfg_data_i;
          REG_DRIFT: drift_q <= cfg_data_i[31:0];
          REG_TEMPC: tempc_q <= cfg_data_i[31:0];
          REG_AGE:   age_q   <= cfg_data_i[31:0];
          default: ;
        endcase
      end
    end
    fail_count = nfail;
    pending    = due_q.size();
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives queries into the holdover error predictor under a series of register
// settings, with random gaps on both channels and a long output stall, and
// reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module testbench;
  import hop_pkg::*;

  localparam logic     OP_PREDICT  = 1'b0;
  localparam logic     OP_TIME     = 1'b1;
  localparam logic [2:0] REG_UNUSED = 3'd5;
  localparam int       NPHASE      = 8;
  localparam int       RAND_ITEMS  = 56;
  localparam int       HOLD_EXTRA  = 80;
  localparam int       DRAIN       = 120;
  localparam int       IDLE_LIMIT  = 4000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;   // elapsed_time[31:0], temp_delta[47:32], threshold[87:48]
  logic        s_axis_tuser = 1'b0; // op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;        // error_value[47:0], time_value[87:48]
  logic        m_axis_tuser;        // time_infinite
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [39:0] cfg_data_i = '0;

  int unsigned fail_count, pending, results_seen;
  int unsigned items_sent = 0;
  int unsigned idle_cycles = 0;
  bit          calm = 0;
  bit          long_hold = 0;
  logic [39:0] cur_base = '0;

  always #1 clk_i = ~clk_i;

  holdover_error_predictor dut (.*);

  holdover_checker chk (.*);

  // receiver side: random stalls, one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_hold = 0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", pending);
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [39:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == REG_BASE) cur_base = value;
  endtask

  task automatic send_query(logic op, logic [31:0] t8, logic [15:0] dtemp, logic [39:0] thr);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {thr, dtemp, t8};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  function automatic logic [39:0] rand40();
    return 40'({$urandom, $urandom});
  endfunction

  task automatic random_query();
    logic [31:0] t8;
    logic [39:0] thr;
    case ($urandom_range(0, 4))
      0: t8 = $urandom;
      1: t8 = $urandom_range(0, 4095);
      2: t8 = $urandom_range(0, 1 << 20);
      3: t8 = 32'hFFFF_FFFF - $urandom_range(0, 255);
      default: t8 = $urandom >> $urandom_range(0, 31);
    endcase
    case ($urandom_range(0, 4))
      0: thr = rand40();
      1: thr = cur_base + $urandom_range(0, 255) - 40'd128;
      2: thr = cur_base + ($urandom >> $urandom_range(0, 31));
      3: thr = rand40() >> $urandom_range(0, 39);
      default: thr = cur_base - ($urandom >> $urandom_range(8, 31));
    endcase
    send_query(1'($urandom_range(0, 1)), t8, 16'($urandom), thr);
  endtask

  task automatic directed_queries();
    send_query(OP_PREDICT, 32'd0, 16'd0, 40'd0);
    send_query(OP_PREDICT, 32'hFFFF_FFFF, 16'h7FFF, 40'd0);
    send_query(OP_PREDICT, 32'hFFFF_FFFF, 16'h8000, 40'd0);
    send_query(OP_PREDICT, 32'd1, 16'hFFFF, 40'hFF_FFFF_FFFF);
    send_query(OP_TIME, 32'd0, 16'h8000, 40'd0);
    send_query(OP_TIME, 32'hFFFF_FFFF, 16'h7FFF, 40'hFF_FFFF_FFFF);
    send_query(OP_TIME, 32'd0, 16'd0, cur_base + 40'd1);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int p = 0; p < NPHASE; p++) begin
      if (p > 0) settle();
      case (p)
        1: begin
          reg_write(REG_BASE, 40'h7F_FFFF_FFFF);
          reg_write(REG_DRIFT, 40'h7FFF_FFFF);
          reg_write(REG_TEMPC, 40'h7FFF_FFFF);
          reg_write(REG_AGE, 40'h7FFF_FFFF);
        end
        2: begin
          reg_write(REG_BASE, 40'h80_0000_0000);
          reg_write(REG_DRIFT, 40'h8000_0000);
          reg_write(REG_TEMPC, 40'h8000_0000);
          reg_write(REG_AGE, 40'h8000_0000);
        end
        3: begin
          reg_write(REG_BASE, 40'd100 << 8);
          reg_write(REG_DRIFT, 40'd2 << 16);
          reg_write(REG_TEMPC, 40'd1 << 12);
          reg_write(REG_AGE, 40'd1 << 16);
          // ignored index, must not disturb the model
          reg_write(REG_UNUSED, rand40());
          long_hold = 1;
        end
        4: begin
          reg_write(REG_AGE, 40'd0);
          reg_write(REG_DRIFT, 40'($urandom_range(1, 1 << 24)));
          reg_write(REG_TEMPC, 40'($urandom));
        end
        5: begin
          reg_write(REG_BASE, 40'($urandom_range(0, 1 << 20)));
          reg_write(REG_DRIFT, 40'hFFFF_0000);
          reg_write(REG_TEMPC, 40'd0);
        end
        6: begin
          reg_write(REG_BASE, rand40());
          reg_write(REG_DRIFT, 40'($urandom));
          reg_write(REG_TEMPC, 40'($urandom));
          reg_write(REG_AGE, 40'($urandom));
        end
        7: begin
          reg_write(REG_BASE, 40'hFF_FFFF_F000);
          reg_write(REG_DRIFT, 40'd300);
          reg_write(REG_TEMPC, 40'hFFFF_FF00);
          reg_write(REG_AGE, 40'd1);
          calm = 1;
        end
        default: ;
      endcase
      if (p < 3) directed_queries();
      // more transactions under the long hold-off than the chain can hold
      for (int i = 0; i < ((p == 3) ? RAND_ITEMS + HOLD_EXTRA : RAND_ITEMS); i++) begin
        // sender waits for the pipeline to drain once mid-phase
        if (p == 4 && i == 30) begin
          s_axis_tvalid <= 1'b0;
          @(posedge clk_i);
          while (pending != 0) @(posedge clk_i);
        end
        random_query();
      end
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    $display("covered %0d queries, %0d results, %0d register settings incl. extremes",
             items_sent, results_seen, NPHASE);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d failures", fail_count);
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
